@@ rtl/core/mbg_pkg.sv @@
// Shared types and constants for the maze backtracker generator.
// Holds the command and result payload structs, code names and the sequencer states.
// Used by mbg_rem_unit, maze_backtracker_generator_unit and sim; depends on nothing.
`default_nettype none

package mbg_pkg;

	localparam int COORD_W = 4;
	localparam int RAND_W  = 16;
	// Bits of the random word consumed per cycle by the remainder unit.
	localparam int DIGIT_W = 4;
	// Wide enough for a neighbor count of zero to four.
	localparam int CNT_W   = 3;
	localparam int REM_W   = 2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [1:0] ACT_STARTED   = 2'd0;
	localparam logic [1:0] ACT_CARVED    = 2'd1;
	localparam logic [1:0] ACT_BACKTRACK = 2'd2;
	localparam logic [1:0] ACT_FINISHED  = 2'd3;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;
	localparam logic [1:0] OPP_OFFSET = 2'd2;

	localparam logic [3:0] ALL_WALLS = 4'hF;

	typedef struct packed {
		logic                command;
		logic [RAND_W-1:0]   random_word;
		logic [COORD_W-1:0]  start_x;
		logic [COORD_W-1:0]  start_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [COORD_W-1:0]  cell_x;
		logic [COORD_W-1:0]  cell_y;
		logic [1:0]          carve_direction;
		logic                maze_done;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE,
		ST_EVAL,
		ST_MOD,
		ST_CARVE_CUR,
		ST_CARVE_NB,
		ST_POP_RD,
		ST_POP_WB
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/mbg_rem_unit.sv @@
// Iterative remainder unit: random word modulo a small neighbor count.
// One restoring compare-subtract per bit, DIGIT_W bits per cycle.
// Depends on mbg_pkg.
`default_nettype none

module mbg_rem_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [mbg_pkg::RAND_W-1:0] dividend,
	input  wire logic [mbg_pkg::CNT_W-1:0]  divisor,
	output logic                            done,
	output logic [mbg_pkg::REM_W-1:0]       rem
);

	localparam int RW    = mbg_pkg::RAND_W;
	localparam int DW    = mbg_pkg::DIGIT_W;
	localparam int CW    = mbg_pkg::CNT_W;
	localparam int STEPS = RW / DW;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic          active_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [RW-1:0] shift_q;
	logic [CW-1:0] div_q;
	logic [mbg_pkg::REM_W-1:0] rem_q;
	logic [mbg_pkg::REM_W-1:0] rem_d;

	// The partial remainder stays below the divisor, so doubling it and adding a bit
	// needs at most one subtraction to bring it back into range.
	always_comb begin
		logic [CW-1:0] r;
		r = CW'(rem_q);
		for (int i = 0; i < DW; i++) begin
			r = {r[CW-2:0], shift_q[RW-1-i]};
			if (r >= div_q) begin
				r = r - div_q;
			end
		end
		rem_d = r[mbg_pkg::REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (active_q) begin
			shift_q <= shift_q << DW;
			rem_q   <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/maze_backtracker_generator_unit.sv @@
// Top level of the maze backtracker generator: sequencer, wall store and path stack.
// Instantiates mbg_rem_unit; types and codes come from mbg_pkg.
//
// Usage: drive cmd and raise start while busy is low; that edge is the transfer.
// Each command gives exactly one result, shown on result for one cycle with done
// high. The receiver cannot stall, so results must be taken when the strobe is up.
// Steps from the transfer to the done cycle:
//   start command: the sweep that writes every wall entry of the wall store
//     back to all walls up;
//   step that carves: probe reads of four neighbor walls and the current cell,
//     evaluation, the remainder of the random word, two wall writes, then the
//     done cycle;
//   step that pops: probe, evaluation, stack read, write-back, done,
//     or done straight after evaluation when the stack is already empty;
//   step after the maze is finished: done is high in the cycle after the transfer.
// One command is handled at a time; busy is high until the result is produced and
// start may be raised again in the cycle that done is high.
// After reset the maze counts as finished, so steps report finished until a start
// command; the wall store holds unknown data until the first start sweeps it.
`default_nettype none

module maze_backtracker_generator_unit #(
	parameter int GRID_SIZE = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mbg_pkg::cmd_t    cmd,
	output logic                  busy,
	output logic                  done,
	output mbg_pkg::result_t      result
);

	localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
	localparam int CW  = $clog2(GRID_SIZE);
	localparam int IW  = $clog2(CELL_COUNT);
	localparam int DW  = $clog2(CELL_COUNT + 1);
	localparam int PXW = mbg_pkg::COORD_W;
	localparam int NW  = mbg_pkg::CNT_W;

	mbg_pkg::state_t state_q, state_d;

	logic [CW-1:0]   cur_x_q, cur_y_q;
	logic [DW-1:0]   depth_q;
	logic [DW-1:0]   visited_q;
	logic [2:0]      probe_q;
	logic [IW-1:0]   clr_q;
	logic [mbg_pkg::RAND_W-1:0] rand_q;
	logic [3:0]      intact_q;
	logic [3:0]      cur_wall_q;
	logic [1:0]      dir_q;
	logic            done_q;
	mbg_pkg::result_t result_q;

	logic [3:0]      wall_mem_q [CELL_COUNT];
	logic [3:0]      wall_rd_q;
	logic [2*CW-1:0] stk_mem_q [CELL_COUNT];
	logic [2*CW-1:0] stk_rd_q;

	logic            accept;
	logic            finished;
	logic            wall_we;
	logic [IW-1:0]   wall_waddr;
	logic [3:0]      wall_wdata;
	logic [IW-1:0]   wall_raddr;
	logic            stk_we;
	logic [DW-1:0]   depth_m1;
	logic            rem_go;
	logic            rem_done;
	logic [mbg_pkg::REM_W-1:0] rem;
	logic [NW-1:0]   cnt;
	logic [1:0]      pick_dir;
	logic [1:0]      opp_dir;
	logic [1:0]      probe_dir;

	logic [CW-1:0]   nb_x [4];
	logic [CW-1:0]   nb_y [4];
	logic [IW-1:0]   nb_addr [4];
	logic [3:0]      nb_in;
	logic [IW-1:0]   cur_addr;

	function automatic logic [IW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return IW'(IW'(x) * IW'(GRID_SIZE) + IW'(y));
	endfunction

	function automatic logic [CW-1:0] clamp_coord(input logic [PXW-1:0] v);
		if (int'(v) >= GRID_SIZE) begin
			return CW'(GRID_SIZE - 1);
		end
		return CW'(v);
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q != mbg_pkg::ST_IDLE);
	assign finished = (visited_q >= DW'(CELL_COUNT));
	assign cnt      = NW'($countones(intact_q));
	assign depth_m1 = depth_q - 1'b1;
	assign opp_dir  = dir_q + mbg_pkg::OPP_OFFSET;
	assign probe_dir = probe_q[1:0];
	assign cur_addr = cell_addr(cur_x_q, cur_y_q);

	// Neighbors of the current cell in north, east, south, west order.
	always_comb begin
		nb_x[mbg_pkg::DIR_NORTH] = cur_x_q;
		nb_y[mbg_pkg::DIR_NORTH] = cur_y_q - 1'b1;
		nb_in[mbg_pkg::DIR_NORTH] = (cur_y_q != '0);
		nb_x[mbg_pkg::DIR_EAST] = cur_x_q + 1'b1;
		nb_y[mbg_pkg::DIR_EAST] = cur_y_q;
		nb_in[mbg_pkg::DIR_EAST] = (cur_x_q != CW'(GRID_SIZE - 1));
		nb_x[mbg_pkg::DIR_SOUTH] = cur_x_q;
		nb_y[mbg_pkg::DIR_SOUTH] = cur_y_q + 1'b1;
		nb_in[mbg_pkg::DIR_SOUTH] = (cur_y_q != CW'(GRID_SIZE - 1));
		nb_x[mbg_pkg::DIR_WEST] = cur_x_q - 1'b1;
		nb_y[mbg_pkg::DIR_WEST] = cur_y_q;
		nb_in[mbg_pkg::DIR_WEST] = (cur_x_q != '0);
		for (int d = 0; d < 4; d++) begin
			nb_addr[d] = cell_addr(nb_x[d], nb_y[d]);
		end
	end

	// The remainder selects the n-th intact neighbor, counting from north.
	always_comb begin
		logic [NW-1:0] seen;
		logic          found;
		seen     = '0;
		found    = 1'b0;
		pick_dir = mbg_pkg::DIR_NORTH;
		for (int d = 0; d < 4; d++) begin
			if (intact_q[d]) begin
				if (!found && seen == NW'(rem)) begin
					pick_dir = 2'(d);
					found    = 1'b1;
				end
				seen = seen + 1'b1;
			end
		end
	end

	mbg_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (rem_go),
		.dividend (rand_q),
		.divisor  (cnt),
		.done     (rem_done),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wall_we    = 1'b0;
		wall_waddr = cur_addr;
		wall_wdata = mbg_pkg::ALL_WALLS;
		wall_raddr = cur_addr;
		stk_we     = 1'b0;
		rem_go     = 1'b0;
		case (state_q)
			mbg_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.command == mbg_pkg::CMD_START) begin
						state_d = mbg_pkg::ST_CLEAR;
					end else if (!finished) begin
						state_d = mbg_pkg::ST_PROBE;
					end
				end
			end
			mbg_pkg::ST_CLEAR: begin
				wall_we    = 1'b1;
				wall_waddr = clr_q;
				if (clr_q == IW'(CELL_COUNT - 1)) begin
					state_d = mbg_pkg::ST_IDLE;
				end
			end
			mbg_pkg::ST_PROBE: begin
				// Out-of-grid directions read the current cell; the result is masked.
				if (probe_q < 3'd4 && nb_in[probe_dir]) begin
					wall_raddr = nb_addr[probe_dir];
				end
				if (probe_q == 3'd5) begin
					state_d = mbg_pkg::ST_EVAL;
				end
			end
			mbg_pkg::ST_EVAL: begin
				if (cnt != '0) begin
					rem_go  = 1'b1;
					state_d = mbg_pkg::ST_MOD;
				end else if (depth_q != '0) begin
					state_d = mbg_pkg::ST_POP_RD;
				end else begin
					state_d = mbg_pkg::ST_IDLE;
				end
			end
			mbg_pkg::ST_MOD: begin
				if (rem_done) begin
					state_d = mbg_pkg::ST_CARVE_CUR;
				end
			end
			mbg_pkg::ST_CARVE_CUR: begin
				wall_we    = 1'b1;
				wall_waddr = cur_addr;
				wall_wdata = cur_wall_q & ~(4'b0001 << dir_q);
				state_d    = mbg_pkg::ST_CARVE_NB;
			end
			mbg_pkg::ST_CARVE_NB: begin
				// The neighbor was intact, so its old value is all walls up.
				wall_we    = 1'b1;
				wall_waddr = nb_addr[dir_q];
				wall_wdata = mbg_pkg::ALL_WALLS & ~(4'b0001 << opp_dir);
				stk_we     = (depth_q < DW'(CELL_COUNT));
				state_d    = mbg_pkg::ST_IDLE;
			end
			mbg_pkg::ST_POP_RD: begin
				state_d = mbg_pkg::ST_POP_WB;
			end
			mbg_pkg::ST_POP_WB: begin
				state_d = mbg_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wall_we) begin
			wall_mem_q[wall_waddr] <= wall_wdata;
		end
		wall_rd_q <= wall_mem_q[wall_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem_q[depth_q[IW-1:0]] <= {cur_x_q, cur_y_q};
		end
		stk_rd_q <= stk_mem_q[depth_m1[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			depth_q   <= '0;
			visited_q <= DW'(CELL_COUNT);
			probe_q   <= '0;
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				mbg_pkg::ST_IDLE: begin
					if (accept) begin
						probe_q <= '0;
						clr_q   <= '0;
						if (cmd.command == mbg_pkg::CMD_START) begin
							cur_x_q   <= clamp_coord(cmd.start_x);
							cur_y_q   <= clamp_coord(cmd.start_y);
							depth_q   <= '0;
							visited_q <= DW'(1);
						end else if (finished) begin
							done_q <= 1'b1;
						end
					end
				end
				mbg_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(CELL_COUNT - 1)) begin
						done_q <= 1'b1;
					end
				end
				mbg_pkg::ST_PROBE: begin
					probe_q <= probe_q + 1'b1;
				end
				mbg_pkg::ST_EVAL: begin
					if (cnt == '0 && depth_q == '0) begin
						done_q <= 1'b1;
					end
				end
				mbg_pkg::ST_CARVE_NB: begin
					cur_x_q   <= nb_x[dir_q];
					cur_y_q   <= nb_y[dir_q];
					visited_q <= visited_q + 1'b1;
					if (depth_q < DW'(CELL_COUNT)) begin
						depth_q <= depth_q + 1'b1;
					end
					done_q <= 1'b1;
				end
				mbg_pkg::ST_POP_RD: begin
					depth_q <= depth_m1;
				end
				mbg_pkg::ST_POP_WB: begin
					cur_x_q <= stk_rd_q[2*CW-1:CW];
					cur_y_q <= stk_rd_q[CW-1:0];
					done_q  <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: the wall data of each probe arrives in the cycle after its read.
	always_ff @(posedge clk) begin
		case (state_q)
			mbg_pkg::ST_IDLE: begin
				if (accept) begin
					rand_q   <= cmd.random_word;
					result_q <= '{action: mbg_pkg::ACT_FINISHED, cell_x: PXW'(cur_x_q),
						cell_y: PXW'(cur_y_q), carve_direction: mbg_pkg::DIR_NORTH,
						maze_done: 1'b1};
				end
			end
			mbg_pkg::ST_CLEAR: begin
				result_q <= '{action: mbg_pkg::ACT_STARTED, cell_x: PXW'(cur_x_q),
					cell_y: PXW'(cur_y_q), carve_direction: mbg_pkg::DIR_NORTH,
					maze_done: finished};
			end
			mbg_pkg::ST_PROBE: begin
				if (probe_q >= 3'd1 && probe_q <= 3'd4) begin
					intact_q[2'(probe_q - 3'd1)] <= nb_in[2'(probe_q - 3'd1)]
						&& (wall_rd_q == mbg_pkg::ALL_WALLS);
				end
				if (probe_q == 3'd5) begin
					cur_wall_q <= wall_rd_q;
				end
			end
			mbg_pkg::ST_EVAL: begin
				result_q <= '{action: mbg_pkg::ACT_BACKTRACK, cell_x: PXW'(cur_x_q),
					cell_y: PXW'(cur_y_q), carve_direction: mbg_pkg::DIR_NORTH,
					maze_done: finished};
			end
			mbg_pkg::ST_MOD: begin
				if (rem_done) begin
					dir_q <= pick_dir;
				end
			end
			mbg_pkg::ST_CARVE_NB: begin
				result_q <= '{action: mbg_pkg::ACT_CARVED, cell_x: PXW'(cur_x_q),
					cell_y: PXW'(cur_y_q), carve_direction: dir_q,
					maze_done: ((visited_q + 1'b1) >= DW'(CELL_COUNT))};
			end
			mbg_pkg::ST_POP_WB: begin
				result_q <= '{action: mbg_pkg::ACT_BACKTRACK,
					cell_x: PXW'(stk_rd_q[2*CW-1:CW]), cell_y: PXW'(stk_rd_q[CW-1:0]),
					carve_direction: mbg_pkg::DIR_NORTH, maze_done: finished};
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	// Every return to idle produces exactly one result.
	a_idle_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sequencer went idle without a result");

	// The chosen position must lie among the intact neighbors.
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (NW'(rem) < cnt))
		else $error("remainder not below neighbor count");

	// A carve adds one visited cell and one stack entry.
	a_carve_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbg_pkg::ST_CARVE_NB) |=>
			(visited_q == DW'($past(visited_q) + 1'b1))
			&& (depth_q == DW'($past(depth_q) + 1'b1)))
		else $error("carve did not advance visited count and stack");

	// The stack never holds more entries than there are visited cells.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mbg_pkg::ST_IDLE) |-> (depth_q < visited_q))
		else $error("stack deeper than visited count");

endmodule

`default_nettype wire

@@ sim/maze_walk_checker.sv @@
// Checker for the maze backtracker generator: watches the command and result channels.
// Keeps its own copy of the wall store, path stack and current cell to predict each result.
// Depends on mbg_pkg for the payload structs and code names.
`default_nettype none

module maze_walk_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire mbg_pkg::cmd_t    cmd,
	input  wire logic             done,
	input  wire mbg_pkg::result_t result,
	output int                    errors,
	output int                    pending
);

	import mbg_pkg::*;

	localparam int GRID  = 16;
	localparam int CELLS = GRID * GRID;

	logic [3:0]         walls [CELLS];
	logic [7:0]         trail [CELLS];
	int                 trail_depth;
	int                 visited;
	logic [COORD_W-1:0] cur_x;
	logic [COORD_W-1:0] cur_y;
	result_t            maze_results_q [$];
	result_t            want;

	function automatic int cell_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		return int'(x) * GRID + int'(y);
	endfunction

	function automatic bit neighbor_of(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [1:0] d, output logic [COORD_W-1:0] nx, output logic [COORD_W-1:0] ny);
		nx = x;
		ny = y;
		case (d)
			DIR_NORTH: begin
				if (y == 0) return 0;
				ny = y - 1'b1;
			end
			DIR_EAST: begin
				if (int'(x) + 1 >= GRID) return 0;
				nx = x + 1'b1;
			end
			DIR_SOUTH: begin
				if (int'(y) + 1 >= GRID) return 0;
				ny = y + 1'b1;
			end
			default: begin
				if (x == 0) return 0;
				nx = x - 1'b1;
			end
		endcase
		return 1;
	endfunction

	// Advances the maze copy by one command and returns the result it should give.
	function automatic result_t next_maze_result(cmd_t c);
		result_t            r;
		bit                 intact [4];
		int                 count;
		int                 pick;
		logic [1:0]         d;
		logic [1:0]         opp;
		logic [COORD_W-1:0] nx;
		logic [COORD_W-1:0] ny;
		logic [7:0]         back;
		r = '0;
		d = DIR_NORTH;
		if (c.command == CMD_START) begin
			foreach (walls[i]) walls[i] = ALL_WALLS;
			cur_x = (int'(c.start_x) >= GRID) ? COORD_W'(GRID - 1) : c.start_x;
			cur_y = (int'(c.start_y) >= GRID) ? COORD_W'(GRID - 1) : c.start_y;
			trail_depth = 0;
			visited = 1;
			r.action = ACT_STARTED;
			r.cell_x = cur_x;
			r.cell_y = cur_y;
		end else if (visited >= CELLS) begin
			r.action = ACT_FINISHED;
			r.cell_x = cur_x;
			r.cell_y = cur_y;
		end else begin
			count = 0;
			for (int k = 0; k < 4; k++) begin
				intact[k] = neighbor_of(cur_x, cur_y, 2'(k), nx, ny)
					&& walls[cell_at(nx, ny)] == ALL_WALLS;
				if (intact[k]) count++;
			end
			if (count > 0) begin
				pick = int'(c.random_word) % count;
				for (int k = 0; k < 4; k++) begin
					if (intact[k]) begin
						if (pick == 0) begin
							d = 2'(k);
							break;
						end
						pick--;
					end
				end
				void'(neighbor_of(cur_x, cur_y, d, nx, ny));
				opp = d + OPP_OFFSET;
				walls[cell_at(cur_x, cur_y)] &= ~(4'b1 << d);
				walls[cell_at(nx, ny)] &= ~(4'b1 << opp);
				if (trail_depth < CELLS) begin
					trail[trail_depth] = 8'(cell_at(cur_x, cur_y));
					trail_depth++;
				end
				r.action = ACT_CARVED;
				r.cell_x = cur_x;
				r.cell_y = cur_y;
				r.carve_direction = d;
				cur_x = nx;
				cur_y = ny;
				visited++;
			end else begin
				if (trail_depth > 0) begin
					trail_depth--;
					back = trail[trail_depth];
					cur_x = COORD_W'(int'(back) / GRID);
					cur_y = COORD_W'(int'(back) % GRID);
				end
				r.action = ACT_BACKTRACK;
				r.cell_x = cur_x;
				r.cell_y = cur_y;
			end
		end
		r.maze_done = (visited >= CELLS);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [3:0] exp_val,
			input logic [3:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val, act_val);
			errors++;
		end
	endtask

	// A result and the next transfer can land on the same edge; the result is matched first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (walls[i]) walls[i] = ALL_WALLS;
			trail_depth = 0;
			cur_x = '0;
			cur_y = '0;
			visited = CELLS;
			maze_results_q.delete();
		end else begin
			if (done === 1'b1) begin
				if (maze_results_q.size() == 0) begin
					$display("%0t: result with nothing expected: actual %p", $time, result);
					errors++;
				end else begin
					want = maze_results_q.pop_front();
					check_field("action", 4'(want.action), 4'(result.action));
					check_field("cell_x", want.cell_x, result.cell_x);
					check_field("cell_y", want.cell_y, result.cell_y);
					check_field("carve_direction", 4'(want.carve_direction),
						4'(result.carve_direction));
					check_field("maze_done", 4'(want.maze_done), 4'(result.maze_done));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				maze_results_q.push_back(next_maze_result(cmd));
		end
		pending = maze_results_q.size();
	end

endmodule

`default_nettype wire

@@ sim/maze_backtracker_generator_unit_test.sv @@
// Testbench top for maze_backtracker_generator_unit: clock, reset, command stimulus and verdict.
// Result checking is done by maze_walk_checker; types and codes come from mbg_pkg.
`default_nettype none

module maze_backtracker_generator_unit_test;

	import mbg_pkg::*;

	localparam int ITEM_TARGET = 1600;
	localparam int STALL_LIMIT = 3000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;
	int      errors;
	int      pending;
	int      sent = 0;
	int      stall_cycles = 0;
	logic    maze_complete;

	always #4 clk = ~clk;

	maze_backtracker_generator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	maze_walk_checker walk_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	// Tracks the last reported maze_done so the stimulus knows when a maze is complete.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_complete <= 1'b1;
		end else if (done) begin
			maze_complete <= result.maze_done;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// Called and returns at a falling edge, after the transfer and any random idle gap.
	task automatic issue(input logic command, input logic [RAND_W-1:0] word,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		cmd.command = command;
		cmd.random_word = word;
		cmd.start_x = x;
		cmd.start_y = y;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
		sent++;
		// Items 500 to 800 go back to back so the block never sees a gap there.
		if ((sent < 500 || sent >= 800) && $urandom_range(0, 99) < 13) begin
			start = 1'b0;
			cmd = cmd_t'($urandom);
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic step(input logic [RAND_W-1:0] word);
		issue(CMD_STEP, word, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic new_maze(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		issue(CMD_START, RAND_W'($urandom), x, y);
	endtask

	initial begin
		int pick;
		int runs;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: step before any start, all four corners, a middle cell, word extremes.
		step(16'hFFFF);
		new_maze(4'd0, 4'd0);
		step(16'h0000);
		step(16'hFFFF);
		step(16'h0001);
		step(16'h0002);
		step(16'h0003);
		new_maze(4'd15, 4'd15);
		step(16'h8000);
		step(16'h7FFF);
		step(16'h0000);
		new_maze(4'd15, 4'd0);
		step(16'h0003);
		step(16'h0002);
		new_maze(4'd0, 4'd15);
		step(16'h0001);
		step(16'hFFFF);
		new_maze(4'd7, 4'd8);
		step(16'h5555);
		step(16'hAAAA);
		step(16'h0000);
		step(16'h0001);

		// Random: mostly complete mazes, some abandoned ones, a little raw noise.
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				new_maze(COORD_W'($urandom), COORD_W'($urandom));
				// The first step is always a carve; after it maze_complete is current again.
				step(RAND_W'($urandom));
				while (!maze_complete && sent < ITEM_TARGET) step(RAND_W'($urandom));
				repeat ($urandom_range(0, 3)) step(RAND_W'($urandom));
			end else if (pick <= 8) begin
				new_maze(COORD_W'($urandom), COORD_W'($urandom));
				runs = $urandom_range(1, 80);
				repeat (runs) step(RAND_W'($urandom));
			end else begin
				runs = $urandom_range(1, 20);
				repeat (runs) issue(1'($urandom), RAND_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom));
			end
		end
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/mbg_pkg.sv
rtl/core/mbg_rem_unit.sv
rtl/core/maze_backtracker_generator_unit.sv
sim/maze_walk_checker.sv
sim/maze_backtracker_generator_unit_test.sv
